/* hdl/mtpc_pkg.sv */
// Shared constants and types for the memory test pattern checker.
package mtpc_pkg;

	localparam int unsigned LINE_BYTES_DEF = 64;
	localparam int unsigned MAX_LINES_DEF  = 1024;

	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_IDX_W  = 2;

	localparam int unsigned ROWS_W  = 17;
	localparam int unsigned BANKS_W = 5;
	localparam int unsigned LINES_W = 11;

	localparam int unsigned ROW_W   = 16;
	localparam int unsigned BANK_W  = 4;
	localparam int unsigned LINE_W  = 10;
	localparam int unsigned BYTE_W  = 6;
	localparam int unsigned ERR_W   = 40;

	localparam logic [ROWS_W-1:0]  ROWS_MAX  = ROWS_W'(65536);
	localparam logic [BANKS_W-1:0] BANKS_MAX = BANKS_W'(16);
	localparam logic [ERR_W-1:0]   ERR_MAX   = {ERR_W{1'b1}};

	localparam logic [ROWS_W-1:0]  ROWS_RST  = ROWS_W'(1);
	localparam logic [BANKS_W-1:0] BANKS_RST = BANKS_W'(1);
	localparam logic [LINES_W-1:0] LINES_RST = LINES_W'(128);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEED  = 2'd0,
		CFG_ROWS  = 2'd1,
		CFG_BANKS = 2'd2,
		CFG_LINES = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic              mismatch;
		logic [7:0]        expected_byte;
		logic [7:0]        observed_byte;
		logic [BANK_W-1:0] bank_at;
		logic [ROW_W-1:0]  row_at;
		logic [LINE_W-1:0] line_at;
		logic [BYTE_W-1:0] byte_at;
		logic [ERR_W-1:0]  error_total;
		logic              run_done;
	} result_t;

endpackage

/* hdl/mtpc_intf.sv */
// Valid/ready channel interfaces for read data in and check results out.
interface mtpc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_byte;

	modport source (output valid, output read_byte, input ready);
	modport sink (input valid, input read_byte, output ready);
endinterface

interface mtpc_out_if;
	logic                                valid;
	logic                                ready;
	logic                                mismatch;
	logic [7:0]                          expected_byte;
	logic [7:0]                          observed_byte;
	logic [mtpc_pkg::BANK_W-1:0]         bank_at;
	logic [mtpc_pkg::ROW_W-1:0]          row_at;
	logic [mtpc_pkg::LINE_W-1:0]         line_at;
	logic [mtpc_pkg::BYTE_W-1:0]         byte_at;
	logic [mtpc_pkg::ERR_W-1:0]          error_total;
	logic                                run_done;

	modport source (output valid, output mismatch, output expected_byte, output observed_byte,
		output bank_at, output row_at, output line_at, output byte_at, output error_total,
		output run_done, input ready);
	modport sink (input valid, input mismatch, input expected_byte, input observed_byte,
		input bank_at, input row_at, input line_at, input byte_at, input error_total,
		input run_done, output ready);
endinterface

/* hdl/memory_test_pattern_checker.sv */
// Memory test pattern checker: compares read-back bytes against a generated pattern.
// Latency: a result is valid in the cycle after its byte is accepted (one result register).
// Throughput: one byte per cycle; the pattern, position and error count state is updated in
// the same cycle as the compare, and the result register stalls only on output backpressure.
// Reset: seed 0, 1 row, 1 bank, 128 lines per row; pattern, positions and error count cleared,
// no result pending. Writing the seed register restarts the run.
module memory_test_pattern_checker #(
	parameter int unsigned LINE_BYTES = mtpc_pkg::LINE_BYTES_DEF,
	parameter int unsigned MAX_LINES  = mtpc_pkg::MAX_LINES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mtpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mtpc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	mtpc_in_if.sink                           in_ch,
	mtpc_out_if.source                        out_ch
);

	localparam int unsigned BW = $clog2(LINE_BYTES);

	localparam logic [BW:0] LAST_BYTE_CNT = (BW+1)'(LINE_BYTES);

	// lines_per_row bound, clamped to what the 11-bit register can hold
	localparam int unsigned LINES_CAP = (MAX_LINES > 2047) ? 2047 : MAX_LINES;
	localparam logic [mtpc_pkg::LINES_W-1:0] LINES_MAX = mtpc_pkg::LINES_W'(LINES_CAP);

	// configuration
	logic [31:0]                       seed_q;
	logic [mtpc_pkg::ROWS_W-1:0]       rows_q;
	logic [mtpc_pkg::BANKS_W-1:0]      banks_q;
	logic [mtpc_pkg::LINES_W-1:0]      lines_q;

	// run state; the line position is as wide as the line bound register
	logic [31:0]                       pattern_q;
	logic [BW-1:0]                     byte_q;
	logic [mtpc_pkg::LINES_W-1:0]      line_q;
	logic [mtpc_pkg::ROW_W-1:0]        row_q;
	logic [mtpc_pkg::BANK_W-1:0]       bank_q;
	logic [mtpc_pkg::ERR_W-1:0]        err_q;

	// result register
	logic                              valid_s1;
	mtpc_pkg::result_t                 res_s1;

	logic                              in_acc;
	logic                              seed_wr;

	logic [mtpc_pkg::ROWS_W-1:0]       rows_c;
	logic [mtpc_pkg::BANKS_W-1:0]      banks_c;
	logic [mtpc_pkg::LINES_W-1:0]      lines_c;
	logic [7:0]                        exp_c;
	logic                              miss_c;
	logic [mtpc_pkg::ERR_W-1:0]        err_c;
	logic                              byte_last_c;
	logic                              line_last_c;
	logic                              row_last_c;
	logic                              bank_last_c;
	logic                              done_c;
	logic [31:0]                       rot_c;
	logic [31:0]                       pattern_c;
	mtpc_pkg::result_t                 res_c;

	assign in_ch.ready = !valid_s1 || out_ch.ready;
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign seed_wr     = cfg_we && (mtpc_pkg::cfg_idx_t'(cfg_index) == mtpc_pkg::CFG_SEED);

	always_comb begin
		// zero bound acts as one, oversized bounds clamp
		if (rows_q == '0) begin
			rows_c = mtpc_pkg::ROWS_W'(1);
		end else if (rows_q > mtpc_pkg::ROWS_MAX) begin
			rows_c = mtpc_pkg::ROWS_MAX;
		end else begin
			rows_c = rows_q;
		end
		if (banks_q == '0) begin
			banks_c = mtpc_pkg::BANKS_W'(1);
		end else if (banks_q > mtpc_pkg::BANKS_MAX) begin
			banks_c = mtpc_pkg::BANKS_MAX;
		end else begin
			banks_c = banks_q;
		end
		if (lines_q == '0) begin
			lines_c = mtpc_pkg::LINES_W'(1);
		end else if (lines_q > LINES_MAX) begin
			lines_c = LINES_MAX;
		end else begin
			lines_c = lines_q;
		end
	end

	always_comb begin
		exp_c  = 8'(pattern_q >> {byte_q[1:0], 3'b000});
		miss_c = exp_c != in_ch.read_byte;
		err_c  = (miss_c && err_q != mtpc_pkg::ERR_MAX) ? err_q + 1'b1 : err_q;

		byte_last_c = ({1'b0, byte_q} + 1'b1) >= LAST_BYTE_CNT;
		line_last_c = ({1'b0, line_q} + 1'b1) >= {1'b0, lines_c};
		row_last_c  = ({1'b0, row_q} + 1'b1) >= rows_c;
		bank_last_c = ({1'b0, bank_q} + 1'b1) >= banks_c;
		done_c      = byte_last_c && line_last_c && row_last_c && bank_last_c;

		rot_c = {pattern_q[0], pattern_q[31:1]};
		// times 3 at the end of a row
		if (line_last_c) begin
			pattern_c = rot_c + {rot_c[30:0], 1'b0};
		end else begin
			pattern_c = rot_c;
		end

		res_c.mismatch      = miss_c;
		res_c.expected_byte = exp_c;
		res_c.observed_byte = in_ch.read_byte;
		res_c.bank_at       = bank_q;
		res_c.row_at        = row_q;
		res_c.line_at       = line_q[mtpc_pkg::LINE_W-1:0];
		res_c.byte_at       = mtpc_pkg::BYTE_W'(32'(byte_q));
		res_c.error_total   = err_c;
		res_c.run_done      = done_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= '0;
			rows_q  <= mtpc_pkg::ROWS_RST;
			banks_q <= mtpc_pkg::BANKS_RST;
			lines_q <= mtpc_pkg::LINES_RST;
		end else if (cfg_we) begin
			case (mtpc_pkg::cfg_idx_t'(cfg_index))
				mtpc_pkg::CFG_SEED:  seed_q  <= cfg_wdata;
				mtpc_pkg::CFG_ROWS:  rows_q  <= mtpc_pkg::ROWS_W'(cfg_wdata);
				mtpc_pkg::CFG_BANKS: banks_q <= mtpc_pkg::BANKS_W'(cfg_wdata);
				mtpc_pkg::CFG_LINES: lines_q <= mtpc_pkg::LINES_W'(cfg_wdata);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			byte_q    <= '0;
			line_q    <= '0;
			row_q     <= '0;
			bank_q    <= '0;
			err_q     <= '0;
		end else if (seed_wr) begin
			pattern_q <= cfg_wdata;
			byte_q    <= '0;
			line_q    <= '0;
			row_q     <= '0;
			bank_q    <= '0;
			err_q     <= '0;
		end else if (in_acc) begin
			if (done_c) begin
				pattern_q <= seed_q;
				byte_q    <= '0;
				line_q    <= '0;
				row_q     <= '0;
				bank_q    <= '0;
				err_q     <= '0;
			end else begin
				err_q <= err_c;
				if (byte_last_c) begin
					byte_q    <= '0;
					pattern_q <= pattern_c;
					if (line_last_c) begin
						line_q <= '0;
						if (row_last_c) begin
							row_q  <= '0;
							bank_q <= bank_q + 1'b1;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end else begin
						line_q <= line_q + 1'b1;
					end
				end else begin
					byte_q <= byte_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_s1 <= res_c;
		end
	end

	assign out_ch.valid         = valid_s1;
	assign out_ch.mismatch      = res_s1.mismatch;
	assign out_ch.expected_byte = res_s1.expected_byte;
	assign out_ch.observed_byte = res_s1.observed_byte;
	assign out_ch.bank_at       = res_s1.bank_at;
	assign out_ch.row_at        = res_s1.row_at;
	assign out_ch.line_at       = res_s1.line_at;
	assign out_ch.byte_at       = res_s1.byte_at;
	assign out_ch.error_total   = res_s1.error_total;
	assign out_ch.run_done      = res_s1.run_done;

	a_seed_restart: assert property (@(posedge clk) disable iff (!arst_n)
		seed_wr |=> (pattern_q == $past(cfg_wdata)) && (err_q == '0) && (byte_q == '0))
		else $error("seed write did not restart the run");

	a_done_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && done_c && !seed_wr) |=> (pattern_q == seed_q) && (err_q == '0)
			&& (line_q == '0) && (row_q == '0) && (bank_q == '0))
		else $error("end of run did not reload state");

	a_err_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !done_c && !seed_wr) |=> err_q >= $past(err_q))
		else $error("error count went down inside a run");

	a_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, byte_q} < LAST_BYTE_CNT))
		else $error("byte position out of line");

	a_miss_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (res_s1.mismatch == (res_s1.expected_byte != res_s1.observed_byte)))
		else $error("mismatch flag disagrees with bytes");

endmodule

/* dv/mtpc_result_checker.sv */
`timescale 1ns / 1ps
// Checker for the pattern checker: tracks pattern and position, predicts and compares every result beat.
module mtpc_result_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mtpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mtpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	mtpc_in_if                              in_ch,
	mtpc_out_if                             out_ch,
	output logic [7:0]                      next_byte,
	output int unsigned                     outstanding,
	output int unsigned                     fail_count
);

	// configuration copy
	logic [31:0]                   seed_q;
	logic [mtpc_pkg::ROWS_W-1:0]   rows_cfg;
	logic [mtpc_pkg::BANKS_W-1:0]  banks_cfg;
	logic [mtpc_pkg::LINES_W-1:0]  lines_cfg;

	// walk state
	logic [31:0]                   pattern_q;
	logic [mtpc_pkg::BYTE_W-1:0]   byte_pos;
	logic [mtpc_pkg::LINE_W-1:0]   line_pos;
	logic [mtpc_pkg::ROW_W-1:0]    row_pos;
	logic [mtpc_pkg::BANK_W-1:0]   bank_pos;
	logic [mtpc_pkg::ERR_W-1:0]    err_q;

	mtpc_pkg::result_t             predicted_results[$];
	mtpc_pkg::result_t             new_result;
	int unsigned                   result_beats;

	// byte the block expects next; lets the stimulus send mostly clean data
	assign next_byte = pattern_q[8*byte_pos[1:0] +: 8];

	function automatic int unsigned eff_bound(int unsigned v, int unsigned hi);
		if (v == 0) return 1;
		return (v > hi) ? hi : v;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0d ns ERROR: %s", $time, what);
		fail_count++;
	endtask

	task automatic restart_run();
		pattern_q = seed_q;
		byte_pos  = '0;
		line_pos  = '0;
		row_pos   = '0;
		bank_pos  = '0;
		err_q     = '0;
	endtask

	task automatic predict_byte_check(input logic [7:0] obs, output mtpc_pkg::result_t r);
		int unsigned rows;
		int unsigned banks;
		int unsigned lines;
		logic [7:0]  want;
		logic        done;
		rows  = eff_bound(32'(rows_cfg), 32'(mtpc_pkg::ROWS_MAX));
		banks = eff_bound(32'(banks_cfg), 32'(mtpc_pkg::BANKS_MAX));
		lines = eff_bound(32'(lines_cfg), mtpc_pkg::MAX_LINES_DEF);
		want  = pattern_q[8*byte_pos[1:0] +: 8];
		done  = 1'b0;
		if (want != obs && err_q != mtpc_pkg::ERR_MAX) err_q++;

		r.mismatch      = (want != obs);
		r.expected_byte = want;
		r.observed_byte = obs;
		r.bank_at       = bank_pos;
		r.row_at        = row_pos;
		r.line_at       = line_pos;
		r.byte_at       = byte_pos;
		r.error_total   = err_q;

		if (byte_pos + 1 >= mtpc_pkg::LINE_BYTES_DEF) begin
			byte_pos  = '0;
			pattern_q = {pattern_q[0], pattern_q[31:1]};
			if (line_pos + 1 >= lines) begin
				line_pos  = '0;
				pattern_q = pattern_q * 32'd3;
				if (row_pos + 1 >= rows) begin
					row_pos = '0;
					if (bank_pos + 1 >= banks) done = 1'b1;
					else bank_pos++;
				end else begin
					row_pos++;
				end
			end else begin
				line_pos++;
			end
		end else begin
			byte_pos++;
		end

		r.run_done = done;
		if (done) restart_run();
	endtask

	task automatic compare_field(input string name, input logic [mtpc_pkg::ERR_W-1:0] got,
			input logic [mtpc_pkg::ERR_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("result beat %0d: %s is %0h, expected %0h",
				result_beats, name, got, want));
	endtask

	task automatic check_result();
		mtpc_pkg::result_t got;
		mtpc_pkg::result_t want;
		result_beats++;
		got.mismatch      = out_ch.mismatch;
		got.expected_byte = out_ch.expected_byte;
		got.observed_byte = out_ch.observed_byte;
		got.bank_at       = out_ch.bank_at;
		got.row_at        = out_ch.row_at;
		got.line_at       = out_ch.line_at;
		got.byte_at       = out_ch.byte_at;
		got.error_total   = out_ch.error_total;
		got.run_done      = out_ch.run_done;
		if (predicted_results.size() == 0) begin
			report_mismatch($sformatf("result beat %0d with no byte outstanding", result_beats));
		end else begin
			want = predicted_results.pop_front();
			compare_field("mismatch", mtpc_pkg::ERR_W'(got.mismatch),
				mtpc_pkg::ERR_W'(want.mismatch));
			compare_field("expected_byte", mtpc_pkg::ERR_W'(got.expected_byte),
				mtpc_pkg::ERR_W'(want.expected_byte));
			compare_field("observed_byte", mtpc_pkg::ERR_W'(got.observed_byte),
				mtpc_pkg::ERR_W'(want.observed_byte));
			compare_field("bank_at", mtpc_pkg::ERR_W'(got.bank_at),
				mtpc_pkg::ERR_W'(want.bank_at));
			compare_field("row_at", mtpc_pkg::ERR_W'(got.row_at),
				mtpc_pkg::ERR_W'(want.row_at));
			compare_field("line_at", mtpc_pkg::ERR_W'(got.line_at),
				mtpc_pkg::ERR_W'(want.line_at));
			compare_field("byte_at", mtpc_pkg::ERR_W'(got.byte_at),
				mtpc_pkg::ERR_W'(want.byte_at));
			compare_field("error_total", got.error_total, want.error_total);
			compare_field("run_done", mtpc_pkg::ERR_W'(got.run_done),
				mtpc_pkg::ERR_W'(want.run_done));
		end
	endtask

	task automatic apply_reg_write();
		case (mtpc_pkg::cfg_idx_t'(cfg_index))
			mtpc_pkg::CFG_SEED: begin
				seed_q = cfg_wdata;
				restart_run();
			end
			mtpc_pkg::CFG_ROWS:  rows_cfg  = cfg_wdata[mtpc_pkg::ROWS_W-1:0];
			mtpc_pkg::CFG_BANKS: banks_cfg = cfg_wdata[mtpc_pkg::BANKS_W-1:0];
			mtpc_pkg::CFG_LINES: lines_cfg = cfg_wdata[mtpc_pkg::LINES_W-1:0];
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q    = '0;
			rows_cfg  = mtpc_pkg::ROWS_RST;
			banks_cfg = mtpc_pkg::BANKS_RST;
			lines_cfg = mtpc_pkg::LINES_RST;
			restart_run();
			predicted_results.delete();
			result_beats = 0;
			outstanding  = 0;
			fail_count   = 0;
		end else begin
			// result first: its byte was accepted at an earlier edge
			if (out_ch.valid && out_ch.ready) check_result();
			if (in_ch.valid && in_ch.ready) begin
				predict_byte_check(in_ch.read_byte, new_result);
				predicted_results.push_back(new_result);
			end
			if (cfg_we) apply_reg_write();
			outstanding = predicted_results.size();
		end
	end

endmodule

/* dv/memory_test_pattern_checker_test.sv */
`timescale 1ns / 1ps
// Bench top for the pattern checker: clock, reset, register writes, byte stimulus and verdict.
module memory_test_pattern_checker_test;

	localparam int unsigned IDLE_LIMIT   = 2000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned PHASES       = 16;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	mtpc_pkg::cfg_idx_t              cfg_index;
	logic [mtpc_pkg::CFG_DATA_W-1:0] cfg_wdata;

	logic [7:0]            next_byte;
	int unsigned           outstanding;
	int unsigned           fail_count;

	int unsigned           send_idle;
	int unsigned           recv_idle;
	int unsigned           stall_request;
	int unsigned           quiet_cycles;

	mtpc_in_if  in_bus();
	mtpc_out_if out_bus();

	memory_test_pattern_checker i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_bus),
		.out_ch    (out_bus)
	);

	mtpc_result_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_ch       (in_bus),
		.out_ch      (out_bus),
		.next_byte   (next_byte),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// result side: random stalls plus an occasional long hold-off
	initial begin : result_sink
		int unsigned hold;
		hold = 0;
		out_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_request != 0) begin
				hold = stall_request;
				stall_request = 0;
			end
			if (hold != 0) begin
				hold--;
				out_bus.ready <= 1'b0;
			end else begin
				out_bus.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic write_reg(input mtpc_pkg::cfg_idx_t idx,
			input logic [mtpc_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// junk above the register width must be dropped
	task automatic write_bound(input mtpc_pkg::cfg_idx_t idx, input int unsigned val,
			input int unsigned w);
		write_reg(idx, (32'($urandom()) << w) | 32'(val));
	endtask

	// entered and left at a falling edge; valid stays up across back-to-back beats
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			in_bus.valid <= 1'b0;
			@(negedge clk);
		end
		in_bus.valid     <= 1'b1;
		in_bus.read_byte <= b;
		@(posedge clk);
		while (!in_bus.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_items(input int unsigned n);
		logic [7:0] b;
		for (int unsigned i = 0; i < n; i++) begin
			b = ($urandom_range(99) < 80) ? next_byte : 8'($urandom());
			send_byte(b);
		end
	endtask

	task automatic finish_burst();
		in_bus.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	initial begin
		logic [mtpc_pkg::CFG_DATA_W-1:0] seed;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = mtpc_pkg::CFG_SEED;
		cfg_wdata        = '0;
		in_bus.valid     = 1'b0;
		in_bus.read_byte = '0;
		send_idle        = 0;
		recv_idle        = 0;
		stall_request    = 0;
		quiet_cycles     = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: seed zero, so every nonzero byte is a miss
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(8'h7F);
		finish_burst();

		write_reg(mtpc_pkg::CFG_SEED, 32'h1234_5678);
		repeat (4) send_byte(next_byte);
		send_byte(~next_byte);
		send_byte(8'hFF);
		finish_burst();

		// zero bounds act as one: one line per run, run_done every 64 bytes
		write_bound(mtpc_pkg::CFG_LINES, 0, mtpc_pkg::LINES_W);
		write_bound(mtpc_pkg::CFG_ROWS, 0, mtpc_pkg::ROWS_W);
		write_bound(mtpc_pkg::CFG_BANKS, 0, mtpc_pkg::BANKS_W);
		write_reg(mtpc_pkg::CFG_SEED, 32'hFFFF_FFFF);
		repeat (6) send_byte(next_byte);
		send_byte(8'h00);
		send_byte(8'h55);
		send_byte(8'hAA);
		finish_burst();

		for (int unsigned p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin send_idle = 0;  recv_idle = 0;  end
				1: begin send_idle = 87; recv_idle = 0;  end
				2: begin send_idle = 0;  recv_idle = 87; end
				default: begin send_idle = 38; recv_idle = 38; end
			endcase
			// no seed write means the new bounds land mid-run
			if (p == 6) begin
				write_bound(mtpc_pkg::CFG_LINES, 2047, mtpc_pkg::LINES_W);
				write_bound(mtpc_pkg::CFG_ROWS, 131071, mtpc_pkg::ROWS_W);
				write_bound(mtpc_pkg::CFG_BANKS, 31, mtpc_pkg::BANKS_W);
			end else if (p == 10) begin
				write_bound(mtpc_pkg::CFG_LINES, mtpc_pkg::MAX_LINES_DEF, mtpc_pkg::LINES_W);
				write_bound(mtpc_pkg::CFG_ROWS, 32'(mtpc_pkg::ROWS_MAX), mtpc_pkg::ROWS_W);
				write_bound(mtpc_pkg::CFG_BANKS, 32'(mtpc_pkg::BANKS_MAX), mtpc_pkg::BANKS_W);
			end else begin
				write_bound(mtpc_pkg::CFG_LINES, $urandom_range(3), mtpc_pkg::LINES_W);
				write_bound(mtpc_pkg::CFG_ROWS, $urandom_range(2), mtpc_pkg::ROWS_W);
				write_bound(mtpc_pkg::CFG_BANKS, $urandom_range(3), mtpc_pkg::BANKS_W);
			end
			if (p == 0 || $urandom_range(1) == 1) begin
				case ($urandom_range(3))
					0: seed = '0;
					1: seed = '1;
					default: seed = $urandom();
				endcase
				write_reg(mtpc_pkg::CFG_SEED, seed);
			end
			// long hold-off on the result side fills the block while bytes keep coming
			if (p == 4) stall_request = 64;
			send_items($urandom_range(40, 80));
			finish_burst();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* memory_test_pattern_checker.f */
hdl/mtpc_pkg.sv
hdl/mtpc_intf.sv
hdl/memory_test_pattern_checker.sv
dv/mtpc_result_checker.sv
dv/memory_test_pattern_checker_test.sv
